[design/block_code_16_8_double_error_decoder_top_defines.svh]
// Assertion macros used by the checker file of the (16,8) decoder.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef BLOCK_CODE_16_8_DOUBLE_ERROR_DECODER_TOP_DEFINES_SVH
`define BLOCK_CODE_16_8_DOUBLE_ERROR_DECODER_TOP_DEFINES_SVH

// Checked only while the block is out of reset.
`define BCDEC_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define BCDEC_CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/bcdec_pkg.sv]
// Package of the (16,8) double-error syndrome decoder: widths, types,
// status codes and the reset contents of the check rows. No dependencies.
`default_nettype none

package bcdec_pkg;

    localparam int NUM_ROWS  = 8;
    localparam int NUM_COLS  = 16;
    localparam int ROW_W     = 8;
    localparam int CW_W      = 16;
    localparam int DATA_W    = 8;
    localparam int SYN_W     = 8;
    localparam int POS_W     = 5;
    localparam int CFG_IDX_W = $clog2(NUM_ROWS);

    typedef logic [ROW_W-1:0]     row_t;
    typedef row_t [NUM_ROWS-1:0]  row_set_t;
    typedef logic [SYN_W-1:0]     col_t;
    typedef col_t [NUM_COLS-1:0]  col_set_t;
    typedef logic [1:0]           status_t;

    localparam status_t STATUS_CLEAN  = 2'd0;
    localparam status_t STATUS_SINGLE = 2'd1;
    localparam status_t STATUS_DOUBLE = 2'd2;
    localparam status_t STATUS_UNCORR = 2'd3;

    // Row 0 sits at index 0.
    localparam row_set_t ROW_RESET = {8'h9F, 8'h5F, 8'h37, 8'h11,
                                      8'h02, 8'h47, 8'hE9, 8'hB2};

    typedef struct packed {
        logic [SYN_W-1:0] syndrome;
        col_set_t         cols;
    } syn_info_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        status_t           status;
        logic [SYN_W-1:0]  syndrome;
        logic [POS_W-1:0]  first_pos;
        logic [POS_W-1:0]  second_pos;
    } dec_result_t;

endpackage

`default_nettype wire

[design/bcdec_in_if.sv]
// Input channel of the decoder: valid/ready handshake carrying one codeword.
// Depends on bcdec_pkg.
`default_nettype none

interface bcdec_in_if import bcdec_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CW_W-1:0] codeword;

    modport source (output valid, output codeword, input ready);
    modport sink   (input valid, input codeword, output ready);
endinterface

`default_nettype wire

[design/bcdec_out_if.sv]
// Result channel of the decoder: valid/ready handshake carrying one result.
// Depends on bcdec_pkg.
`default_nettype none

interface bcdec_out_if import bcdec_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    status_t           status;
    logic [SYN_W-1:0]  syndrome;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  second_pos;

    modport source (output valid, output data_out, output status, output syndrome,
                    output first_pos, output second_pos, input ready);
    modport sink   (input valid, input data_out, input status, input syndrome,
                    input first_pos, input second_pos, output ready);
endinterface

`default_nettype wire

[design/bcdec_cfg.sv]
// Register file holding the data part of the eight parity-check rows.
// Depends on bcdec_pkg.
`default_nettype none

module bcdec_cfg
    import bcdec_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ROW_W-1:0]     cfg_wdata,
    output row_set_t                  h_rows
);

    row_set_t h_row_reg;
    row_set_t h_row_next;

    always_comb
    begin
        h_row_next = h_row_reg;
        if (cfg_we)
        begin
            h_row_next[cfg_index] = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_row_reg <= ROW_RESET;
        end
        else
        begin
            h_row_reg <= h_row_next;
        end
    end

    assign h_rows = h_row_reg;

endmodule

`default_nettype wire

[design/bcdec_syndrome.sv]
// Syndrome and parity-check column generation for one codeword.
// Depends on bcdec_pkg.
`default_nettype none

module bcdec_syndrome
    import bcdec_pkg::*;
(
    input  wire logic [CW_W-1:0] codeword,
    input  row_set_t             h_rows,
    output syn_info_t            info
);

    always_comb
    begin
        info = '0;
        // Syndrome bit 7-k is the parity of row k over the data byte,
        // plus the check bit picked by the identity part of that row.
        for (int k = 0; k < NUM_ROWS; k++)
        begin
            info.syndrome[SYN_W-1-k] = ^(codeword[CW_W-1 -: DATA_W] & h_rows[k])
                                       ^ codeword[ROW_W-1-k];
        end
        // Column idx belongs to codeword bit 15-idx; row 0 lands in the MSB.
        for (int idx = 0; idx < NUM_COLS; idx++)
        begin
            for (int k = 0; k < NUM_ROWS; k++)
            begin
                if (idx < DATA_W)
                begin
                    info.cols[idx][SYN_W-1-k] = h_rows[k][ROW_W-1-idx];
                end
                else
                begin
                    info.cols[idx][SYN_W-1-k] = (k == idx - DATA_W);
                end
            end
        end
    end

endmodule

`default_nettype wire

[design/bcdec_search.sv]
// Ordered single and pair column match and correction of the data byte.
// Depends on bcdec_pkg.
`default_nettype none

module bcdec_search
    import bcdec_pkg::*;
(
    input  wire logic [CW_W-1:0] codeword,
    input  syn_info_t            info,
    output dec_result_t          result
);

    logic [NUM_COLS-1:0]                single_hit;
    logic [NUM_COLS-1:0][NUM_COLS-1:0]  pair_hit;
    logic [CW_W-1:0]                    flip;

    // All comparisons are independent of one another.
    always_comb
    begin
        single_hit = '0;
        pair_hit   = '0;
        for (int j = 0; j < NUM_COLS; j++)
        begin
            single_hit[j] = (info.cols[j] == info.syndrome);
        end
        for (int p = 0; p < NUM_COLS - 1; p++)
        begin
            for (int j = p + 1; j < NUM_COLS; j++)
            begin
                pair_hit[p][j] = ((info.cols[p] ^ info.cols[j]) == info.syndrome);
            end
        end
    end

    // Priority selection: walked from the lowest priority up, so the
    // earliest match in scan order is the last one written.
    always_comb
    begin
        result            = '0;
        flip              = '0;
        result.status     = STATUS_UNCORR;
        result.syndrome   = info.syndrome;
        for (int p = NUM_COLS - 2; p >= 0; p--)
        begin
            for (int j = NUM_COLS - 1; j > p; j--)
            begin
                if (pair_hit[p][j])
                begin
                    flip              = '0;
                    flip[CW_W-1-p]    = 1'b1;
                    flip[CW_W-1-j]    = 1'b1;
                    result.status     = STATUS_DOUBLE;
                    result.first_pos  = POS_W'(p + 1);
                    result.second_pos = POS_W'(j + 1);
                end
            end
        end
        for (int j = NUM_COLS - 1; j >= 0; j--)
        begin
            if (single_hit[j])
            begin
                flip              = '0;
                flip[CW_W-1-j]    = 1'b1;
                result.status     = STATUS_SINGLE;
                result.first_pos  = POS_W'(j + 1);
                result.second_pos = '0;
            end
        end
        if (info.syndrome == '0)
        begin
            flip              = '0;
            result.status     = STATUS_CLEAN;
            result.first_pos  = '0;
            result.second_pos = '0;
        end
        result.data_out = codeword[CW_W-1 -: DATA_W] ^ flip[CW_W-1 -: DATA_W];
    end

endmodule

`default_nettype wire

[design/block_code_16_8_double_error_decoder_top.sv]
// Top level of the (16,8) double-error syndrome decoder.
// Depends on bcdec_pkg, bcdec_in_if, bcdec_out_if, bcdec_cfg,
// bcdec_syndrome and bcdec_search.
//
// Usage notes:
// - word_ch carries one 16-bit codeword per transaction: data byte in bits
//   15..8, check byte in bits 7..0. result_ch carries one result per
//   transaction: corrected data byte, status, syndrome and the one-based
//   positions of the corrected bits.
// - The configuration port writes the data part of check row cfg_index on
//   any clock edge with cfg_we high. Write it only while no transaction is
//   in flight; rows take effect on the next codeword that is decoded.
// - The datapath is two registers deep: an input register and a result
//   register with the syndrome, column match and correction logic between
//   them. A codeword accepted into the input register is decoded there and
//   moves into the result register, from which it is offered on result_ch.
// - Throughput is one codeword per cycle unless result_ch stalls; the rate
//   is set by the single combinational decode pass between the two registers.
// - When the receiver stalls, the result register holds its transaction
//   and the input register still takes one more codeword; word_ch.ready
//   drops only when both registers are full.
// - Reset empties both registers and loads the default check rows.
`default_nettype none

module block_code_16_8_double_error_decoder_top
    import bcdec_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ROW_W-1:0]     cfg_wdata,
    bcdec_in_if.sink                  word_ch,
    bcdec_out_if.source               result_ch
);

    row_set_t        h_rows;
    syn_info_t       info;
    dec_result_t     dec_result;

    logic            in_valid_reg;
    logic            in_valid_next;
    logic [CW_W-1:0] codeword_reg;
    logic [CW_W-1:0] codeword_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    dec_result_t     result_reg;
    dec_result_t     result_next;

    logic            stage1_ready;
    logic            stage2_ready;

    // Each stage can load when it is empty or its contents move on.
    assign stage2_ready  = !out_valid_reg || result_ch.ready;
    assign stage1_ready  = !in_valid_reg || stage2_ready;
    assign word_ch.ready = stage1_ready;

    bcdec_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .h_rows    (h_rows)
    );

    bcdec_syndrome u_syndrome (
        .codeword (codeword_reg),
        .h_rows   (h_rows),
        .info     (info)
    );

    bcdec_search u_search (
        .codeword (codeword_reg),
        .info     (info),
        .result   (dec_result)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        codeword_next  = codeword_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (stage1_ready)
        begin
            in_valid_next = word_ch.valid;
            if (word_ch.valid)
            begin
                codeword_next = word_ch.codeword;
            end
        end
        if (stage2_ready)
        begin
            out_valid_next = in_valid_reg;
            if (in_valid_reg)
            begin
                result_next = dec_result;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        codeword_reg <= codeword_next;
        result_reg   <= result_next;
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.data_out   = result_reg.data_out;
    assign result_ch.status     = result_reg.status;
    assign result_ch.syndrome   = result_reg.syndrome;
    assign result_ch.first_pos  = result_reg.first_pos;
    assign result_ch.second_pos = result_reg.second_pos;

endmodule

`default_nettype wire

[design/bcdec_checker.sv]
// Port-level checker for the (16,8) decoder and its bind to the top level.
// Depends on bcdec_pkg and the assertion macro header.
`default_nettype none

`include "block_code_16_8_double_error_decoder_top_defines.svh"

module bcdec_checker
    import bcdec_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [DATA_W-1:0] data_out,
    input wire status_t           status,
    input wire logic [SYN_W-1:0]  syndrome,
    input wire logic [POS_W-1:0]  first_pos,
    input wire logic [POS_W-1:0]  second_pos
);

    // A result is clean exactly when its syndrome is zero.
    `BCDEC_CHECK(a_clean_iff_zero_syn, out_valid |-> ((syndrome == '0) == (status == STATUS_CLEAN)), "clean status and zero syndrome disagree")

    // Positions must agree with the number of corrected bits.
    `BCDEC_CHECK(a_pos_match_status, out_valid |-> (((status == STATUS_CLEAN || status == STATUS_UNCORR) && first_pos == '0 && second_pos == '0) || (status == STATUS_SINGLE && first_pos != '0 && second_pos == '0) || (status == STATUS_DOUBLE && first_pos != '0 && first_pos < second_pos)), "corrected positions inconsistent with status")

    // A stalled result must hold.
    `BCDEC_CHECK(a_stall_hold, (out_valid && !out_ready) |=> (out_valid && $stable(data_out) && $stable(status) && $stable(syndrome) && $stable(first_pos) && $stable(second_pos)), "stalled result changed")

    // Reset leaves no result pending.
    `BCDEC_CHECK_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result offered right after reset")

endmodule

bind block_code_16_8_double_error_decoder_top bcdec_checker u_bcdec_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .data_out   (result_ch.data_out),
    .status     (result_ch.status),
    .syndrome   (result_ch.syndrome),
    .first_pos  (result_ch.first_pos),
    .second_pos (result_ch.second_pos)
);

`default_nettype wire

[bench/block_code_16_8_double_error_decoder_top_tb.sv]
// Self-checking bench for the (16,8) double-error syndrome decoder: a directed
// table, then phases of random codewords under random check rows and stalls.
// Depends on bcdec_pkg, bcdec_in_if, bcdec_out_if and the decoder top level.
`default_nettype none

module block_code_16_8_double_error_decoder_top_tb
    import bcdec_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to let pass after the last result before a row write or the end
    // of the run. The datapath is two registers deep.
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_WORDS   = 1830;
    // Longest stretch without any transaction before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {
        PLAN_WORD,          // send one codeword
        PLAN_FILL_ROWS,     // write every check row with the same value
        PLAN_DEFAULT_ROWS   // write the reset contents back into every row
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t  kind;
        row_t        fill;
        logic [15:0] cw;
        logic        typed;   // expectation is written out in the table
        dec_result_t want;
    } plan_row_t;

    typedef struct packed {
        logic [15:0] cw;
        dec_result_t want;
    } pending_t;

    localparam int PLAN_LEN = 23;

    // Directed table. Rows with typed set carry an expectation that can be
    // checked by hand; the others are checked against the predictor.
    localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
        // Default rows: clean zero word and single errors at both ends.
        '{PLAN_WORD, 8'h00, 16'h0000, 1'b1, '{8'h00, STATUS_CLEAN,  8'h00, 5'd0,  5'd0}},
        '{PLAN_WORD, 8'h00, 16'h8000, 1'b1, '{8'h00, STATUS_SINGLE, 8'hC1, 5'd1,  5'd0}},
        '{PLAN_WORD, 8'h00, 16'h0080, 1'b1, '{8'h00, STATUS_SINGLE, 8'h80, 5'd9,  5'd0}},
        '{PLAN_WORD, 8'h00, 16'h0001, 1'b1, '{8'h00, STATUS_SINGLE, 8'h01, 5'd16, 5'd0}},
        '{PLAN_WORD, 8'h00, 16'hFFFF, 1'b0, '0},
        '{PLAN_WORD, 8'h00, 16'h00FF, 1'b0, '0},
        '{PLAN_WORD, 8'h00, 16'hFF00, 1'b0, '0},
        '{PLAN_WORD, 8'h00, 16'hC000, 1'b0, '0},
        '{PLAN_WORD, 8'h00, 16'h8001, 1'b0, '0},
        '{PLAN_WORD, 8'h00, 16'h0003, 1'b0, '0},
        '{PLAN_WORD, 8'h00, 16'h0007, 1'b0, '0},
        '{PLAN_WORD, 8'h00, 16'hA5C3, 1'b0, '0},
        // All-zero rows: the data columns vanish, the syndrome is the check
        // byte, and three set check bits cannot be matched.
        '{PLAN_FILL_ROWS, 8'h00, 16'h0000, 1'b0, '0},
        '{PLAN_WORD, 8'h00, 16'h0007, 1'b1, '{8'h00, STATUS_UNCORR, 8'h07, 5'd0,  5'd0}},
        '{PLAN_WORD, 8'h00, 16'hFF00, 1'b1, '{8'hFF, STATUS_CLEAN,  8'h00, 5'd0,  5'd0}},
        '{PLAN_WORD, 8'h00, 16'hAB05, 1'b1, '{8'hAB, STATUS_DOUBLE, 8'h05, 5'd14, 5'd16}},
        '{PLAN_WORD, 8'h00, 16'h1202, 1'b1, '{8'h12, STATUS_SINGLE, 8'h02, 5'd15, 5'd0}},
        // All-ones rows: every data column is equal, so the first one wins.
        '{PLAN_FILL_ROWS, 8'hFF, 16'h0000, 1'b0, '0},
        '{PLAN_WORD, 8'h00, 16'h0100, 1'b0, '0},
        '{PLAN_WORD, 8'h00, 16'hFFFF, 1'b0, '0},
        '{PLAN_WORD, 8'h00, 16'h0300, 1'b0, '0},
        '{PLAN_DEFAULT_ROWS, 8'h00, 16'h0000, 1'b0, '0},
        '{PLAN_WORD, 8'h00, 16'h5A5A, 1'b0, '0}
    };

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0]     cfg_wdata;

    bcdec_in_if  word_ch ();
    bcdec_out_if result_ch ();

    block_code_16_8_double_error_decoder_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .word_ch   (word_ch),
        .result_ch (result_ch)
    );

    // Bench copy of the check rows, kept in step with every row write.
    row_set_t check_rows;
    // Decodes owed by the block, oldest first.
    pending_t pending_decodes[$];

    int errors;
    int words_sent;
    int results_seen;
    int row_writes;
    int status_seen[4];
    bit tx_gaps;     // sender idles between transactions
    bit rx_stalls;   // receiver stalls between transactions

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Column idx of the full check matrix; idx 0 is codeword bit 15 and
    // row 0 lands in the column's MSB.
    function automatic col_t matrix_column(input int idx);
        col_t        c;
        logic [15:0] full;
        for (int k = 0; k < NUM_ROWS; k++)
        begin
            full = {check_rows[k], 8'h80 >> k};
            c[7-k] = full[15-idx];
        end
        return c;
    endfunction

    // Predicts the decoder's output for one codeword under the current rows.
    function automatic dec_result_t decode_codeword(input logic [15:0] cw);
        dec_result_t r;
        logic [15:0] fixed;
        logic [15:0] full;
        col_t        cols [NUM_COLS];
        bit          found;
        r = '0;
        r.status = STATUS_UNCORR;
        fixed = cw;
        found = 1'b0;
        for (int k = 0; k < NUM_ROWS; k++)
        begin
            full = {check_rows[k], 8'h80 >> k};
            r.syndrome[7-k] = ^(cw & full);
        end
        for (int j = 0; j < NUM_COLS; j++)
            cols[j] = matrix_column(j);
        if (r.syndrome == '0)
        begin
            r.status = STATUS_CLEAN;
            found = 1'b1;
        end
        for (int j = 0; j < NUM_COLS && !found; j++)
        begin
            if (cols[j] == r.syndrome)
            begin
                fixed = cw ^ (16'h8000 >> j);
                r.status = STATUS_SINGLE;
                r.first_pos = POS_W'(j + 1);
                found = 1'b1;
            end
        end
        for (int p = 0; p + 1 < NUM_COLS && !found; p++)
        begin
            for (int j = p + 1; j < NUM_COLS && !found; j++)
            begin
                if ((cols[p] ^ cols[j]) == r.syndrome)
                begin
                    fixed = cw ^ (16'h8000 >> p) ^ (16'h8000 >> j);
                    r.status = STATUS_DOUBLE;
                    r.first_pos = POS_W'(p + 1);
                    r.second_pos = POS_W'(j + 1);
                    found = 1'b1;
                end
            end
        end
        r.data_out = fixed[15:8];
        return r;
    endfunction

    // Builds a codeword with a zero syndrome under the current rows, so that
    // injected errors land on a known-good word.
    function automatic logic [15:0] encode_data(input logic [7:0] data);
        logic [15:0] cw;
        cw = {data, 8'h00};
        for (int k = 0; k < NUM_ROWS; k++)
            cw[7-k] = ^(data & check_rows[k]);
        return cw;
    endfunction

    task automatic flag_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Lowers valid and waits until every owed decode has come back. Always
    // advances at least one edge so that the caller may raise valid again.
    task automatic drain_results();
        word_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_decodes.size() != 0);
    endtask

    // Writes all eight check rows while the block is idle.
    task automatic write_rows(input row_set_t vals);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int k = 0; k < NUM_ROWS; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(k);
            cfg_wdata <= vals[k];
            check_rows[k] = vals[k];
            row_writes++;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Offers one codeword transaction and records what it should decode to.
    // Called at a clock edge at which valid has not yet been assigned.
    task automatic send_word(input logic [15:0] cw, input bit typed,
                             input dec_result_t want);
        int       gap;
        pending_t entry;
        gap = tx_gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            word_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_ch.valid    <= 1'b1;
        word_ch.codeword <= cw;
        // Signals read right after the edge still hold the values the block
        // sampled at that edge, since every bench input moves by NBA.
        do
            @(posedge clk);
        while (!word_ch.ready);
        entry.cw = cw;
        entry.want = typed ? want : decode_codeword(cw);
        pending_decodes.push_back(entry);
        words_sent++;
    endtask

    // Picks the rows for one random phase: defaults, fully random, sparse,
    // or degenerate with zero and repeated rows.
    function automatic row_set_t pick_rows();
        row_set_t v;
        int       style;
        style = $urandom_range(0, 3);
        for (int k = 0; k < NUM_ROWS; k++)
        begin
            case (style)
                0: v[k] = ROW_RESET[k];
                1: v[k] = row_t'($urandom);
                2: v[k] = row_t'($urandom & $urandom & $urandom);
                default:
                begin
                    if (k == 0 || $urandom_range(0, 2) == 0)
                        v[k] = ($urandom_range(0, 1) == 0) ? row_t'(0) : row_t'($urandom);
                    else
                        v[k] = v[$urandom_range(0, k - 1)];
                end
            endcase
        end
        return v;
    endfunction

    // Draws one random codeword. Most are valid words with zero to three
    // flipped bits, so the single, double and uncorrectable paths are all
    // exercised; the rest are raw noise and all-zero or all-one words.
    function automatic logic [15:0] pick_codeword();
        logic [15:0] cw;
        logic [15:0] flips;
        int          nerr;
        int          sel;
        sel = $urandom_range(0, 19);
        if (sel < 2)
            return 16'($urandom);
        if (sel == 2)
            return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
        sel = $urandom_range(0, 19);
        if (sel < 3)
            nerr = 0;
        else if (sel < 10)
            nerr = 1;
        else if (sel < 17)
            nerr = 2;
        else
            nerr = 3;
        cw = encode_data(8'($urandom));
        flips = '0;
        while ($countones(flips) < nerr)
            flips[$urandom_range(0, 15)] = 1'b1;
        return cw ^ flips;
    endfunction

    // Result side: random stalls on ready, and every result transaction is
    // compared field by field with the oldest owed decode.
    always @(posedge clk)
    begin : result_side
        int       stall_left;
        bit       ready_next;
        pending_t head;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (pending_decodes.size() == 0)
                    flag_mismatch("result transaction with no decode owed");
                else
                begin
                    head = pending_decodes.pop_front();
                    status_seen[head.want.status]++;
                    if (result_ch.data_out !== head.want.data_out)
                        flag_mismatch($sformatf("cw %h data_out %h, want %h", head.cw,
                                      result_ch.data_out, head.want.data_out));
                    if (result_ch.status !== head.want.status)
                        flag_mismatch($sformatf("cw %h status %0d, want %0d", head.cw,
                                      result_ch.status, head.want.status));
                    if (result_ch.syndrome !== head.want.syndrome)
                        flag_mismatch($sformatf("cw %h syndrome %h, want %h", head.cw,
                                      result_ch.syndrome, head.want.syndrome));
                    if (result_ch.first_pos !== head.want.first_pos)
                        flag_mismatch($sformatf("cw %h first_pos %0d, want %0d", head.cw,
                                      result_ch.first_pos, head.want.first_pos));
                    if (result_ch.second_pos !== head.want.second_pos)
                        flag_mismatch($sformatf("cw %h second_pos %0d, want %0d", head.cw,
                                      result_ch.second_pos, head.want.second_pos));
                end
                stall_left = rx_stalls ? $urandom_range(0, 15) : 0;
                ready_next = (stall_left == 0);
            end
            else if (!result_ch.ready)
            begin
                if (stall_left > 0)
                    stall_left--;
                ready_next = (stall_left == 0);
            end
            else
                ready_next = 1'b1;
            result_ch.ready <= ready_next;
        end
    end

    // Watchdog: a long run of cycles with no transaction on either channel
    // means the block has hung.
    always @(posedge clk)
    begin : watchdog
        int quiet_cycles;
        if ((word_ch.valid && word_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int        phase_len;
        row_set_t  fill_rows;
        // Every block input holds a known value from time zero.
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        word_ch.valid = 1'b0;
        word_ch.codeword = '0;
        result_ch.ready = 1'b0;
        check_rows = ROW_RESET;
        errors = 0;
        words_sent = 0;
        results_seen = 0;
        row_writes = 0;
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, straight after reset with the default rows.
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            case (DIRECTED_PLAN[i].kind)
                PLAN_WORD:
                    send_word(DIRECTED_PLAN[i].cw, DIRECTED_PLAN[i].typed,
                              DIRECTED_PLAN[i].want);
                PLAN_FILL_ROWS:
                begin
                    for (int k = 0; k < NUM_ROWS; k++)
                        fill_rows[k] = DIRECTED_PLAN[i].fill;
                    write_rows(fill_rows);
                end
                default:
                    write_rows(ROW_RESET);
            endcase
        end

        // Random phases. Each one settles new rows while the block is idle
        // and draws whether either side idles; some phases run flat out.
        while (words_sent < PLAN_LEN + RANDOM_WORDS)
        begin
            write_rows(pick_rows());
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(40, 160);
            for (int n = 0; n < phase_len && words_sent < PLAN_LEN + RANDOM_WORDS; n++)
            begin
                send_word(pick_codeword(), 1'b0, '0);
                // Now and then the sender holds off until the block is empty.
                if ($urandom_range(0, 63) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d codewords and %0d row writes over varied check rows",
                 words_sent, row_writes);
        $display("decodes seen: %0d clean, %0d single, %0d double, %0d uncorrectable",
                 status_seen[STATUS_CLEAN], status_seen[STATUS_SINGLE],
                 status_seen[STATUS_DOUBLE], status_seen[STATUS_UNCORR]);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+design
design/bcdec_pkg.sv
design/bcdec_in_if.sv
design/bcdec_out_if.sv
design/bcdec_cfg.sv
design/bcdec_syndrome.sv
design/bcdec_search.sv
design/block_code_16_8_double_error_decoder_top.sv
design/bcdec_checker.sv
bench/block_code_16_8_double_error_decoder_top_tb.sv
